>>> rtl/cpci_pkg.sv
`timescale 1ns / 1ps

package cpci_pkg;

   localparam int MAGW      = 17;
   localparam int SQW       = 2 * MAGW;
   localparam int D2W       = SQW + 1;
   localparam int DISTW     = 18;
   localparam int NRMW      = 15;
   localparam int NQW       = NRMW + 1;
   localparam int NNW       = MAGW + NRMW + 1;
   localparam int RESTW     = 9;
   localparam int REST_FRAC = 8;
   localparam int KW        = RESTW + 1;
   localparam int RADW      = 16;
   localparam int MASSW     = 16;

   localparam logic [RESTW-1:0] REST_RESET = 9'd218;

   typedef enum logic [1:0] {
      ST_APART      = 2'd0,
      ST_SEPARATED  = 2'd1,
      ST_IMPULSE    = 2'd2,
      ST_COINCIDENT = 2'd3
   } cpci_status_type;

endpackage

>>> rtl/cpci_isqrt.sv
`timescale 1ns / 1ps

module cpci_isqrt import cpci_pkg::*; #(
   parameter int SW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [D2W-1:0]   in_rad,
   input  logic [SW-1:0]    in_side,
   output logic             out_valid,
   output logic [DISTW-1:0] out_root,
   output logic [SW-1:0]    out_side
);

   localparam int TW = D2W + 1;

   logic [D2W-1:0]   rem_ff  [DISTW];
   logic [DISTW-1:0] root_ff [DISTW];
   logic [SW-1:0]    side_ff [DISTW];
   logic [DISTW-1:0] vld_ff;

   for (genvar k = 0; k < DISTW; k++) begin : g_stage
      localparam int B = DISTW - 1 - k;
      logic [D2W-1:0]   rem_prev;
      logic [DISTW-1:0] root_prev;
      logic [SW-1:0]    side_prev;
      logic             vld_prev;
      logic [TW-1:0]    trial;
      logic             take;
      logic [D2W-1:0]   rem_in;
      logic [DISTW-1:0] root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = in_rad;
         assign root_prev = '0;
         assign side_prev = in_side;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      assign trial   = (TW'(root_prev) << (B + 1)) + (TW'(1) << (2 * B));
      assign take    = TW'(rem_prev) >= trial;
      assign rem_in  = take ? D2W'(TW'(rem_prev) - trial) : rem_prev;
      assign root_in = take ? (root_prev | (DISTW'(1) << B)) : root_prev;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end
   end

   assign out_valid = vld_ff[DISTW-1];
   assign out_root  = root_ff[DISTW-1];
   assign out_side  = side_ff[DISTW-1];

endmodule

>>> rtl/cpci_div.sv
`timescale 1ns / 1ps

module cpci_div #(
   parameter int NW = 33,
   parameter int DW = 18,
   parameter int QW = 16,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num_a,
   input  logic [NW-1:0] in_num_b,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo_a,
   output logic [QW-1:0] out_quo_b,
   output logic [SW-1:0] out_side
);

   localparam int RW = (NW > DW + QW) ? NW : DW + QW;

   logic [RW-1:0] rema_ff [QW];
   logic [RW-1:0] remb_ff [QW];
   logic [QW-1:0] qa_ff   [QW];
   logic [QW-1:0] qb_ff   [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [SW-1:0] side_ff [QW];
   logic [QW-1:0] vld_ff;

   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int B = QW - 1 - k;
      logic [RW-1:0] ra_prev, rb_prev, sh;
      logic [QW-1:0] qa_prev, qb_prev;
      logic [DW-1:0] den_prev;
      logic [SW-1:0] side_prev;
      logic          vld_prev;
      logic          ta, tb;
      logic [RW-1:0] rema_in, remb_in;
      logic [QW-1:0] qa_in, qb_in;

      if (k == 0) begin : g_first
         assign ra_prev   = RW'(in_num_a);
         assign rb_prev   = RW'(in_num_b);
         assign qa_prev   = '0;
         assign qb_prev   = '0;
         assign den_prev  = in_den;
         assign side_prev = in_side;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign ra_prev   = rema_ff[k-1];
         assign rb_prev   = remb_ff[k-1];
         assign qa_prev   = qa_ff[k-1];
         assign qb_prev   = qb_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      assign sh      = RW'(den_prev) << B;
      assign ta      = ra_prev >= sh;
      assign tb      = rb_prev >= sh;
      assign rema_in = ta ? ra_prev - sh : ra_prev;
      assign remb_in = tb ? rb_prev - sh : rb_prev;
      assign qa_in   = ta ? (qa_prev | (QW'(1) << B)) : qa_prev;
      assign qb_in   = tb ? (qb_prev | (QW'(1) << B)) : qb_prev;

      always_ff @(posedge clock) begin
         if (en) begin
            rema_ff[k] <= rema_in;
            remb_ff[k] <= remb_in;
            qa_ff[k]   <= qa_in;
            qb_ff[k]   <= qb_in;
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo_a = qa_ff[QW-1];
   assign out_quo_b = qb_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

>>> rtl/circle_pair_collision_impulse_top.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake                Payload
// req_*    in   req_tvalid / req_tready  pair of circles (tdata)
// rsp_*    out  rsp_tvalid / rsp_tready  resolved pair (tdata), contact status (tuser)
// csr_*    in   csr_valid / csr_ready    restitution, Q1.8, 9 bit
//
// One transaction per cycle in each direction unless a held result stalls the pipeline; the pipeline
// holds the 18-stage square root and the two divider pipelines (16 and COORD_WIDTH + 4 stages).
// Reset clears the valid bits and loads restitution with 218 (0.85).
// A held result freezes every stage at once; req_tready drops with it, nothing is lost.

module circle_pair_collision_impulse_top import cpci_pkg::*; #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius, a_mass,
   // b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius, b_mass
   input  logic [((8*COORD_WIDTH+4*16+7)/8)*8-1:0]       req_tdata,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y,
   // new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y
   output logic [((8*COORD_WIDTH+7)/8)*8-1:0]            rsp_tdata,
   // contact_status
   output logic [1:0]                                    rsp_tuser,
   input  logic                                          csr_valid,
   output logic                                          csr_ready,
   input  logic [RESTW-1:0]                              csr_data
);

   localparam int CW      = COORD_WIDTH;
   localparam int OUT_TDW = ((8*CW+7)/8)*8;
   localparam int PXW     = NQW + 1 + CW + 1;
   localparam int SSW     = PXW + 1;
   localparam int MSW     = CW + 17;
   localparam int MPW     = MAGW + NQW;
   localparam int MXW     = MPW + 1 - NRMW;
   localparam int PRW     = MSW + KW;
   localparam int JSH     = NRMW + REST_FRAC;
   localparam int JW      = CW + 4;
   localparam int MW      = JW + MASSW;
   localparam int NUMW    = MW + 1;
   localparam int VPW     = JW + NQW;
   localparam int DAW     = VPW + 1 - NRMW;
   localparam int WW      = CW + 8;

   localparam logic [MPW:0] MRND = (MPW+1)'(1) << (NRMW - 1);
   localparam logic [PRW:0] JRND = (PRW+1)'(1) << (JSH - 1);
   localparam logic [VPW:0] VRND = (VPW+1)'(1) << (NRMW - 1);
   localparam logic signed [WW-1:0] SAT_HI = WW'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [WW-1:0] SAT_LO = -SAT_HI - WW'(1);

   typedef struct packed {
      logic signed [CW-1:0] ax;
      logic signed [CW-1:0] ay;
      logic signed [CW-1:0] avx;
      logic signed [CW-1:0] avy;
      logic signed [CW-1:0] bx;
      logic signed [CW-1:0] by;
      logic signed [CW-1:0] bvx;
      logic signed [CW-1:0] bvy;
      logic [MASSW-1:0]     am;
      logic [MASSW-1:0]     bm;
      logic signed [CW:0]   dvx;
      logic signed [CW:0]   dvy;
      logic [MAGW-1:0]      rsum;
      logic                 sdx;
      logic                 sdy;
      logic [MAGW-1:0]      mdx;
      logic [MAGW-1:0]      mdy;
      logic                 coinc;
      logic                 near;
      logic                 hit;
      logic [DISTW-1:0]     span;
      logic [MAGW-1:0]      ovl;
      logic [NQW-1:0]       nmx;
      logic [NQW-1:0]       nmy;
      cpci_status_type      stat;
   } item_type;

   localparam int IW = $bits(item_type);

   function automatic logic signed [CW-1:0] sat(input logic signed [WW-1:0] v);
      logic signed [WW-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI;
      end else if (v < SAT_LO) begin
         r = SAT_LO;
      end else begin
         r = v;
      end
      return r[CW-1:0];
   endfunction

   logic en;
   logic [RESTW-1:0] rest_ff;

   logic signed [CW-1:0] in_ax, in_ay, in_avx, in_avy, in_bx, in_by, in_bvx, in_bvy;
   logic [RADW-1:0]  in_ar, in_br;
   logic [MASSW-1:0] in_am, in_bm;

   assign in_ax  = $signed(req_tdata[0*CW +: CW]);
   assign in_ay  = $signed(req_tdata[1*CW +: CW]);
   assign in_avx = $signed(req_tdata[2*CW +: CW]);
   assign in_avy = $signed(req_tdata[3*CW +: CW]);
   assign in_ar  = req_tdata[4*CW +: RADW];
   assign in_am  = req_tdata[4*CW+16 +: MASSW];
   assign in_bx  = $signed(req_tdata[4*CW+32 +: CW]);
   assign in_by  = $signed(req_tdata[5*CW+32 +: CW]);
   assign in_bvx = $signed(req_tdata[6*CW+32 +: CW]);
   assign in_bvy = $signed(req_tdata[7*CW+32 +: CW]);
   assign in_br  = req_tdata[8*CW+32 +: RADW];
   assign in_bm  = req_tdata[8*CW+48 +: MASSW];

   logic out_vld_ff;
   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff <= REST_RESET;
      end else if (csr_valid) begin
         rest_ff <= csr_data;
      end
   end

   // stage 1: differences, radius sum
   item_type s1_item_in, s1_item_ff;
   logic signed [CW:0] s1_dx_in, s1_dy_in, s1_dx_ff, s1_dy_ff;

   always_comb begin
      s1_item_in      = '0;
      s1_item_in.ax   = in_ax;
      s1_item_in.ay   = in_ay;
      s1_item_in.avx  = in_avx;
      s1_item_in.avy  = in_avy;
      s1_item_in.bx   = in_bx;
      s1_item_in.by   = in_by;
      s1_item_in.bvx  = in_bvx;
      s1_item_in.bvy  = in_bvy;
      s1_item_in.am   = in_am;
      s1_item_in.bm   = in_bm;
      s1_item_in.dvx  = (CW+1)'(in_bvx) - (CW+1)'(in_avx);
      s1_item_in.dvy  = (CW+1)'(in_bvy) - (CW+1)'(in_avy);
      s1_item_in.rsum = MAGW'(in_ar) + MAGW'(in_br);
      s1_item_in.stat = ST_APART;
      s1_dx_in        = (CW+1)'(in_bx) - (CW+1)'(in_ax);
      s1_dy_in        = (CW+1)'(in_by) - (CW+1)'(in_ay);
   end

   // stage 2: magnitudes, box test
   item_type s2_item_in, s2_item_ff;
   logic [CW:0] s2_magx, s2_magy;

   always_comb begin
      s2_magx          = s1_dx_ff[CW] ? (CW+1)'(-s1_dx_ff) : (CW+1)'(s1_dx_ff);
      s2_magy          = s1_dy_ff[CW] ? (CW+1)'(-s1_dy_ff) : (CW+1)'(s1_dy_ff);
      s2_item_in       = s1_item_ff;
      s2_item_in.sdx   = s1_dx_ff[CW];
      s2_item_in.sdy   = s1_dy_ff[CW];
      s2_item_in.mdx   = s2_magx[MAGW-1:0];
      s2_item_in.mdy   = s2_magy[MAGW-1:0];
      s2_item_in.coinc = (s1_dx_ff == '0) && (s1_dy_ff == '0);
      s2_item_in.near  = (s2_magx <= (CW+1)'(s1_item_ff.rsum)) &&
                         (s2_magy <= (CW+1)'(s1_item_ff.rsum));
   end

   // stage 3: squares, stage 4: squared distance
   logic [SQW-1:0] s3_sqx_in, s3_sqy_in, s3_sqx_ff, s3_sqy_ff;
   item_type s3_item_ff, s4_item_ff;
   logic [D2W-1:0] s4_d2_in, s4_d2_ff;

   assign s3_sqx_in = SQW'(s2_item_ff.mdx) * SQW'(s2_item_ff.mdx);
   assign s3_sqy_in = SQW'(s2_item_ff.mdy) * SQW'(s2_item_ff.mdy);
   assign s4_d2_in  = D2W'(s3_sqx_ff) + D2W'(s3_sqy_ff);

   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_item_ff <= s1_item_in;
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
         s2_item_ff <= s2_item_in;
         s3_item_ff <= s2_item_ff;
         s3_sqx_ff  <= s3_sqx_in;
         s3_sqy_ff  <= s3_sqy_in;
         s4_item_ff <= s3_item_ff;
         s4_d2_ff   <= s4_d2_in;
      end
   end

   // square root
   logic             q_vld;
   logic [DISTW-1:0] q_dist;
   logic [IW-1:0]    q_side;
   item_type         q_item;

   cpci_isqrt #(.SW(IW)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_vld_ff),
      .in_rad    (s4_d2_ff),
      .in_side   (s4_item_ff),
      .out_valid (q_vld),
      .out_root  (q_dist),
      .out_side  (q_side)
   );

   assign q_item = item_type'(q_side);

   // stage 5: overlap, normal numerators
   item_type s5_item_in, s5_item_ff;
   logic signed [DISTW:0] s5_ovl;
   logic [NNW-1:0] s5_numx_in, s5_numy_in, s5_numx_ff, s5_numy_ff;
   logic s5_vld_ff;

   always_comb begin
      s5_ovl          = $signed((DISTW+1)'(q_item.rsum)) - $signed((DISTW+1)'(q_dist));
      s5_item_in      = q_item;
      s5_item_in.span = q_dist;
      s5_item_in.ovl  = s5_ovl[MAGW-1:0];
      s5_item_in.hit  = q_item.near && !q_item.coinc && !s5_ovl[DISTW] && (s5_ovl != '0);
      s5_numx_in      = (NNW'(q_item.mdx) << NRMW) + NNW'(q_dist >> 1);
      s5_numy_in      = (NNW'(q_item.mdy) << NRMW) + NNW'(q_dist >> 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_item_ff <= s5_item_in;
         s5_numx_ff <= s5_numx_in;
         s5_numy_ff <= s5_numy_in;
      end
   end

   // unit normal
   logic           n_vld;
   logic [NQW-1:0] n_qx, n_qy;
   logic [IW-1:0]  n_side;
   item_type       n_item;

   cpci_div #(.NW(NNW), .DW(DISTW), .QW(NQW), .SW(IW)) u_div_nrm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_vld_ff),
      .in_num_a  (s5_numx_ff),
      .in_num_b  (s5_numy_ff),
      .in_den    (s5_item_ff.span),
      .in_side   (s5_item_ff),
      .out_valid (n_vld),
      .out_quo_a (n_qx),
      .out_quo_b (n_qy),
      .out_side  (n_side)
   );

   always_comb begin
      n_item     = item_type'(n_side);
      n_item.nmx = n_qx;
      n_item.nmy = n_qy;
   end

   // P0: signed normal
   item_type p0_item_ff;
   logic signed [NQW:0] p0_nx_in, p0_ny_in, p0_nx_ff, p0_ny_ff;

   assign p0_nx_in = n_item.sdx ? -$signed((NQW+1)'(n_qx)) : $signed((NQW+1)'(n_qx));
   assign p0_ny_in = n_item.sdy ? -$signed((NQW+1)'(n_qy)) : $signed((NQW+1)'(n_qy));

   // P1: projections and push products
   item_type p1_item_ff;
   logic signed [PXW-1:0] p1_px_in, p1_py_in, p1_px_ff, p1_py_ff;
   logic [MPW-1:0] p1_mpx_in, p1_mpy_in, p1_mpx_ff, p1_mpy_ff;

   assign p1_px_in  = PXW'(p0_nx_ff) * PXW'(p0_item_ff.dvx);
   assign p1_py_in  = PXW'(p0_ny_ff) * PXW'(p0_item_ff.dvy);
   assign p1_mpx_in = MPW'(p0_item_ff.ovl) * MPW'(p0_item_ff.nmx);
   assign p1_mpy_in = MPW'(p0_item_ff.ovl) * MPW'(p0_item_ff.nmy);

   // P2: closing speed, rounded push
   item_type p2_item_ff;
   logic signed [SSW-1:0] p2_s_in, p2_s_ff;
   logic [MPW:0]   p2_rx, p2_ry;
   logic [MXW-1:0] p2_mx_in, p2_my_in, p2_mx_ff, p2_my_ff;

   assign p2_s_in  = SSW'(p1_px_ff) + SSW'(p1_py_ff);
   assign p2_rx    = (MPW+1)'(p1_mpx_ff) + MRND;
   assign p2_ry    = (MPW+1)'(p1_mpy_ff) + MRND;
   assign p2_mx_in = p2_rx[MPW:NRMW];
   assign p2_my_in = p2_ry[MPW:NRMW];

   // P3: separation, status
   item_type p3_item_in, p3_item_ff;
   logic [MSW-1:0] p3_mags_in, p3_mags_ff;
   logic signed [WW-1:0] p3_wx, p3_wy;

   always_comb begin
      p3_wx      = p2_item_ff.sdx ? -$signed(WW'(p2_mx_ff)) : $signed(WW'(p2_mx_ff));
      p3_wy      = p2_item_ff.sdy ? -$signed(WW'(p2_my_ff)) : $signed(WW'(p2_my_ff));
      p3_item_in = p2_item_ff;
      p3_mags_in = MSW'(-p2_s_ff);
      if (p2_item_ff.coinc) begin
         p3_item_in.stat = ST_COINCIDENT;
      end else if (p2_item_ff.hit) begin
         p3_item_in.ax   = sat(WW'(p2_item_ff.ax) - p3_wx);
         p3_item_in.ay   = sat(WW'(p2_item_ff.ay) - p3_wy);
         p3_item_in.bx   = sat(WW'(p2_item_ff.bx) + p3_wx);
         p3_item_in.by   = sat(WW'(p2_item_ff.by) + p3_wy);
         p3_item_in.stat = p2_s_ff[SSW-1] ? ST_IMPULSE : ST_SEPARATED;
      end else begin
         p3_item_in.stat = ST_APART;
      end
   end

   // P4: restitution scaling
   item_type p4_item_ff;
   logic [PRW-1:0] p4_prod_in, p4_prod_ff;

   assign p4_prod_in = PRW'(p3_mags_ff) * PRW'(KW'(1 << REST_FRAC) + KW'(rest_ff));

   // P5: impulse, mass weights
   item_type p5_item_ff;
   logic [PRW:0]     p5_jr;
   logic [JW-1:0]    p5_jv_in, p5_jv_ff;
   logic [MASSW-1:0] p5_wa_in, p5_wb_in, p5_wa_ff, p5_wb_ff;
   logic [MAGW-1:0]  p5_ws_in, p5_ws_ff;
   logic             p5_nomass;

   assign p5_jr     = (PRW+1)'(p4_prod_ff) + JRND;
   assign p5_jv_in  = JW'(p5_jr >> JSH);
   assign p5_nomass = (p4_item_ff.am == '0) && (p4_item_ff.bm == '0);
   assign p5_wa_in  = p5_nomass ? MASSW'(1) : p4_item_ff.am;
   assign p5_wb_in  = p5_nomass ? MASSW'(1) : p4_item_ff.bm;
   assign p5_ws_in  = MAGW'(p5_wa_in) + MAGW'(p5_wb_in);

   // P6: weighted impulse, P7: rounding offset
   item_type p6_item_ff, p7_item_ff;
   logic [MW-1:0]   p6_ma_in, p6_mb_in, p6_ma_ff, p6_mb_ff;
   logic [MAGW-1:0] p6_ws_ff, p7_ws_ff;
   logic [NUMW-1:0] p7_na_in, p7_nb_in, p7_na_ff, p7_nb_ff;

   assign p6_ma_in = MW'(p5_jv_ff) * MW'(p5_wb_ff);
   assign p6_mb_in = MW'(p5_jv_ff) * MW'(p5_wa_ff);
   assign p7_na_in = NUMW'(p6_ma_ff) + NUMW'(p6_ws_ff >> 1);
   assign p7_nb_in = NUMW'(p6_mb_ff) + NUMW'(p6_ws_ff >> 1);

   logic p0_vld_ff, p1_vld_ff, p2_vld_ff, p3_vld_ff, p4_vld_ff, p5_vld_ff;
   logic p6_vld_ff, p7_vld_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p0_item_ff <= n_item;
         p0_nx_ff   <= p0_nx_in;
         p0_ny_ff   <= p0_ny_in;
         p1_item_ff <= p0_item_ff;
         p1_px_ff   <= p1_px_in;
         p1_py_ff   <= p1_py_in;
         p1_mpx_ff  <= p1_mpx_in;
         p1_mpy_ff  <= p1_mpy_in;
         p2_item_ff <= p1_item_ff;
         p2_s_ff    <= p2_s_in;
         p2_mx_ff   <= p2_mx_in;
         p2_my_ff   <= p2_my_in;
         p3_item_ff <= p3_item_in;
         p3_mags_ff <= p3_mags_in;
         p4_item_ff <= p3_item_ff;
         p4_prod_ff <= p4_prod_in;
         p5_item_ff <= p4_item_ff;
         p5_jv_ff   <= p5_jv_in;
         p5_wa_ff   <= p5_wa_in;
         p5_wb_ff   <= p5_wb_in;
         p5_ws_ff   <= p5_ws_in;
         p6_item_ff <= p5_item_ff;
         p6_ma_ff   <= p6_ma_in;
         p6_mb_ff   <= p6_mb_in;
         p6_ws_ff   <= p5_ws_ff;
         p7_item_ff <= p6_item_ff;
         p7_na_ff   <= p7_na_in;
         p7_nb_ff   <= p7_nb_in;
         p7_ws_ff   <= p6_ws_ff;
      end
   end

   // mass split
   logic          j_vld;
   logic [JW-1:0] j_a, j_b;
   logic [IW-1:0] j_side;
   item_type      j_item;

   cpci_div #(.NW(NUMW), .DW(MAGW), .QW(JW), .SW(IW)) u_div_share (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p7_vld_ff),
      .in_num_a  (p7_na_ff),
      .in_num_b  (p7_nb_ff),
      .in_den    (p7_ws_ff),
      .in_side   (p7_item_ff),
      .out_valid (j_vld),
      .out_quo_a (j_a),
      .out_quo_b (j_b),
      .out_side  (j_side)
   );

   assign j_item = item_type'(j_side);

   // V1: per-axis products, V2: rounding
   item_type v1_item_ff, v2_item_ff;
   logic [VPW-1:0] v1_pax_ff, v1_pay_ff, v1_pbx_ff, v1_pby_ff;
   logic [VPW:0]   v2_rax, v2_ray, v2_rbx, v2_rby;
   logic [DAW-1:0] v2_dax_ff, v2_day_ff, v2_dbx_ff, v2_dby_ff;

   assign v2_rax = (VPW+1)'(v1_pax_ff) + VRND;
   assign v2_ray = (VPW+1)'(v1_pay_ff) + VRND;
   assign v2_rbx = (VPW+1)'(v1_pbx_ff) + VRND;
   assign v2_rby = (VPW+1)'(v1_pby_ff) + VRND;

   // V3: velocity update into the output register
   logic signed [WW-1:0] v3_wax, v3_way, v3_wbx, v3_wby;
   logic signed [CW-1:0] v3_avx, v3_avy, v3_bvx, v3_bvy;
   logic [OUT_TDW-1:0]   out_data_in, out_data_ff;
   cpci_status_type      out_stat_ff;
   logic v1_vld_ff, v2_vld_ff;

   always_comb begin
      v3_wax = v2_item_ff.sdx ? -$signed(WW'(v2_dax_ff)) : $signed(WW'(v2_dax_ff));
      v3_way = v2_item_ff.sdy ? -$signed(WW'(v2_day_ff)) : $signed(WW'(v2_day_ff));
      v3_wbx = v2_item_ff.sdx ? -$signed(WW'(v2_dbx_ff)) : $signed(WW'(v2_dbx_ff));
      v3_wby = v2_item_ff.sdy ? -$signed(WW'(v2_dby_ff)) : $signed(WW'(v2_dby_ff));
      v3_avx = v2_item_ff.avx;
      v3_avy = v2_item_ff.avy;
      v3_bvx = v2_item_ff.bvx;
      v3_bvy = v2_item_ff.bvy;
      if (v2_item_ff.stat == ST_IMPULSE) begin
         v3_avx = sat(WW'(v2_item_ff.avx) - v3_wax);
         v3_avy = sat(WW'(v2_item_ff.avy) - v3_way);
         v3_bvx = sat(WW'(v2_item_ff.bvx) + v3_wbx);
         v3_bvy = sat(WW'(v2_item_ff.bvy) + v3_wby);
      end
      out_data_in = OUT_TDW'({v3_bvy, v3_bvx, v2_item_ff.by, v2_item_ff.bx,
                              v3_avy, v3_avx, v2_item_ff.ay, v2_item_ff.ax});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v1_item_ff  <= j_item;
         v1_pax_ff   <= VPW'(j_a) * VPW'(j_item.nmx);
         v1_pay_ff   <= VPW'(j_a) * VPW'(j_item.nmy);
         v1_pbx_ff   <= VPW'(j_b) * VPW'(j_item.nmx);
         v1_pby_ff   <= VPW'(j_b) * VPW'(j_item.nmy);
         v2_item_ff  <= v1_item_ff;
         v2_dax_ff   <= v2_rax[VPW:NRMW];
         v2_day_ff   <= v2_ray[VPW:NRMW];
         v2_dbx_ff   <= v2_rbx[VPW:NRMW];
         v2_dby_ff   <= v2_rby[VPW:NRMW];
         out_data_ff <= out_data_in;
         out_stat_ff <= v2_item_ff.stat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         p0_vld_ff  <= 1'b0;
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         p3_vld_ff  <= 1'b0;
         p4_vld_ff  <= 1'b0;
         p5_vld_ff  <= 1'b0;
         p6_vld_ff  <= 1'b0;
         p7_vld_ff  <= 1'b0;
         v1_vld_ff  <= 1'b0;
         v2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff  <= req_tvalid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         s5_vld_ff  <= q_vld;
         p0_vld_ff  <= n_vld;
         p1_vld_ff  <= p0_vld_ff;
         p2_vld_ff  <= p1_vld_ff;
         p3_vld_ff  <= p2_vld_ff;
         p4_vld_ff  <= p3_vld_ff;
         p5_vld_ff  <= p4_vld_ff;
         p6_vld_ff  <= p5_vld_ff;
         p7_vld_ff  <= p6_vld_ff;
         v1_vld_ff  <= j_vld;
         v2_vld_ff  <= v1_vld_ff;
         out_vld_ff <= v2_vld_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_stat_ff;

   // a real separation must come from a pair that passed the box test
   a_hit_near: assert property (@(posedge clock) disable iff (reset)
      p3_vld_ff && (p3_item_ff.stat == ST_SEPARATED || p3_item_ff.stat == ST_IMPULSE)
      |-> p3_item_ff.near && !p3_item_ff.coinc)
      else $error("separation on a pair outside the box test");

   // distinct centres never give a zero root
   a_dist_nonzero: assert property (@(posedge clock) disable iff (reset)
      s5_vld_ff && s5_item_ff.near && !s5_item_ff.coinc |-> s5_item_ff.span != '0)
      else $error("zero distance for distinct centres");

   // normal components never exceed one
   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      p0_vld_ff && p0_item_ff.hit
      |-> p0_item_ff.nmx <= (NQW'(1) << NRMW) && p0_item_ff.nmy <= (NQW'(1) << NRMW))
      else $error("normal component above unity");

   // a stalled pipeline keeps the next result in place
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en && v2_vld_ff |=> v2_vld_ff && $stable(v2_item_ff))
      else $error("pipeline moved during a stall");

endmodule
